// ===== hdl/id3fw_pkg.sv =====
// Package for the tag frame walker: field widths, parse phases, status codes
// and the structs that carry an item between the modules.
// No dependencies.
package id3fw_pkg;

   localparam int unsigned POS_W   = 29;  // byte offset in the file
   localparam int unsigned NEXT_W  = 34;  // offset of the next frame header
   localparam int unsigned TOTAL_W = 29;  // tag end, header included
   localparam int unsigned PAD_W   = 28;
   localparam int unsigned COUNT_W = 25;
   localparam int unsigned ACC_W   = 32;  // frame size field
   localparam int unsigned IDX_W   = 3;   // byte index inside a frame header
   localparam int unsigned HDR_LEN = 10;  // tag header and frame header length

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_SEEK,
      PH_FHDR,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_TAG  = 2'd1,
      ST_EARLY   = 2'd2,
      ST_OVERRUN = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic                 tag_found;
      logic [7:0]           version_major;
      logic [7:0]           version_revision;
      logic [7:0]           header_flags;
      logic [TOTAL_W-1:0]   total_tag_size;
      logic [COUNT_W-1:0]   frame_count;
      logic [PAD_W-1:0]     padding_size;
      status_type           status;
   } rsp_type;

   // The three marker bytes "ID3" at file offsets 0 to 2.
   function automatic logic [7:0] marker_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'h49;
         2'd1:    val = 8'h44;
         2'd2:    val = 8'h33;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// ===== hdl/id3fw_in_reg.sv =====
// Input register of the frame walker: holds one byte item until the walker
// takes it. Depends on id3fw_pkg.
module id3fw_in_reg
   import id3fw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    take,
   output logic    item_valid,
   output req_type item_data
);

   logic    valid_ff, valid_in;
   req_type data_ff;

   assign req_ready  = !valid_ff || take;
   assign valid_in   = (req_valid && req_ready) || (valid_ff && !take);
   assign item_valid = valid_ff;
   assign item_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

endmodule

// ===== hdl/id3fw_walker.sv =====
// Parse state of the frame walker: header check, frame walk and the summary
// built from the state each byte leaves behind. Depends on id3fw_pkg.
module id3fw_walker
   import id3fw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type item,
   output logic    emit,
   output rsp_type result
);

   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [7:0]         major_ff, major_in;
   logic [7:0]         rev_ff, rev_in;
   logic [7:0]         flags_ff, flags_in;
   logic [TOTAL_W-1:0] tag_end_ff, tag_end_in;
   logic [NEXT_W-1:0]  next_ff, next_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [COUNT_W-1:0] frames_ff, frames_in;

   logic [7:0]         b;
   logic [PAD_W-1:0]   size_shift;
   logic               no_tag, finish, early;
   logic [NEXT_W:0]    diff;
   logic               found;

   assign b = item.data_byte;
   assign size_shift = {tag_end_ff[PAD_W-8:0], b[6:0]};

   // Signed distance from the walk position to the tag end; its sign tells
   // an overrun and its value is the padding.
   assign diff = {{(NEXT_W + 1 - TOTAL_W){1'b0}}, tag_end_in} - {1'b0, next_in};

   // Next state.
   always_comb begin
      phase_in   = phase_ff;
      major_in   = major_ff;
      rev_in     = rev_ff;
      flags_in   = flags_ff;
      tag_end_in = tag_end_ff;
      next_in    = next_ff;
      idx_in     = idx_ff;
      acc_in     = acc_ff;
      frames_in  = frames_ff;
      no_tag     = 1'b0;
      finish     = 1'b0;
      case (phase_ff)
         PH_HEADER: begin
            if (pos_ff < POS_W'(3)) begin
               if (b != marker_byte(pos_ff[1:0])) begin
                  no_tag   = 1'b1;
                  phase_in = PH_DONE;
               end
            end else if (pos_ff == POS_W'(3)) begin
               major_in = b;
            end else if (pos_ff == POS_W'(4)) begin
               rev_in = b;
            end else if (pos_ff == POS_W'(5)) begin
               flags_in = b;
            end else if (pos_ff == POS_W'(9)) begin
               tag_end_in = {1'b0, size_shift} + TOTAL_W'(HDR_LEN);
               next_in    = NEXT_W'(HDR_LEN);
               if (size_shift == '0) begin
                  finish   = 1'b1;
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_SEEK;
               end
            end else begin
               tag_end_in = {1'b0, size_shift};
            end
         end
         PH_SEEK: begin
            if ({{(NEXT_W - POS_W){1'b0}}, pos_ff} == next_ff) begin
               if (b inside {[8'h30:8'h39], [8'h41:8'h5A]}) begin
                  frames_in = frames_ff + COUNT_W'(1);
                  idx_in    = IDX_W'(1);
                  acc_in    = '0;
                  phase_in  = PH_FHDR;
               end else begin
                  finish   = 1'b1;
                  phase_in = PH_DONE;
               end
            end
         end
         PH_FHDR: begin
            if (idx_ff >= IDX_W'(4)) begin
               acc_in = {acc_ff[ACC_W-9:0], b};
            end
            if (idx_ff == IDX_W'(7)) begin
               next_in = next_ff + {{(NEXT_W - ACC_W){1'b0}}, acc_in} + NEXT_W'(HDR_LEN);
               idx_in  = '0;
               // Reaching or passing the tag end closes the walk.
               if (diff[NEXT_W] || diff == '0) begin
                  finish   = 1'b1;
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_SEEK;
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase
      pos_in = (phase_in != PH_DONE) ? pos_ff + POS_W'(1) : pos_ff;
   end

   // Summary for this byte, taken from the state it leaves behind.
   always_comb begin
      early = item.end_of_stream && (phase_in != PH_DONE);
      emit  = no_tag || finish || early;
      found = finish || (early && ((phase_in != PH_HEADER) || (pos_in >= POS_W'(3))));
      result.tag_found        = found;
      result.version_major    = found ? major_in : '0;
      result.version_revision = found ? rev_in : '0;
      result.header_flags     = found ? flags_in : '0;
      result.total_tag_size   = '0;
      result.frame_count      = frames_in;
      result.padding_size     = '0;
      result.status           = ST_OK;
      if (no_tag) begin
         result.status = ST_NO_TAG;
      end else if (finish) begin
         result.total_tag_size = tag_end_in;
         if (diff[NEXT_W]) begin
            result.status = ST_OVERRUN;
         end else begin
            result.padding_size = diff[PAD_W-1:0];
         end
      end else begin
         result.status = ST_EARLY;
         if (phase_in != PH_HEADER) begin
            result.total_tag_size = tag_end_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && item.end_of_stream)) begin
         phase_ff   <= PH_HEADER;
         pos_ff     <= '0;
         major_ff   <= '0;
         rev_ff     <= '0;
         flags_ff   <= '0;
         tag_end_ff <= '0;
         next_ff    <= NEXT_W'(HDR_LEN);
         idx_ff     <= '0;
         acc_ff     <= '0;
         frames_ff  <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         major_ff   <= major_in;
         rev_ff     <= rev_in;
         flags_ff   <= flags_in;
         tag_end_ff <= tag_end_in;
         next_ff    <= next_in;
         idx_ff     <= idx_in;
         acc_ff     <= acc_in;
         frames_ff  <= frames_in;
      end
   end

   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      fire && phase_ff == PH_DONE |-> !emit)
      else $error("walker produced a summary after the walk had ended");

   a_idx_only_in_fhdr: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_FHDR |-> idx_ff == '0)
      else $error("frame header index left set outside a frame header");

   a_header_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEADER |-> pos_ff < POS_W'(HDR_LEN))
      else $error("header phase ran past the tag header");

   a_walk_inside_tag: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SEEK |-> next_ff < {{(NEXT_W - TOTAL_W){1'b0}}, tag_end_ff})
      else $error("frame walk continued at or past the tag end");

endmodule

// ===== hdl/id3fw_out_reg.sv =====
// Result register of the frame walker: holds one summary item until the
// consumer takes it. Depends on id3fw_pkg.
module id3fw_out_reg
   import id3fw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    space,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign space     = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> space)
      else $error("summary loaded over one that was not taken");

endmodule

// ===== hdl/id3v2_tag_frame_walker.sv =====
// Top level of the tag frame walker: input register, parse state and result
// register. Depends on id3fw_pkg, id3fw_in_reg, id3fw_walker, id3fw_out_reg.
//
//   channel | direction | payload                                   | handshake
//   req     | in        | data_byte, end_of_stream                  | req_valid/req_ready
//   rsp     | out       | tag_found .. status, one summary per file | rsp_valid/rsp_ready
//
// One byte item per cycle sustained unless a summary stalls; a byte is parsed from
// the input register and its summary, if any, is offered in the cycle after that.
// The parse step is one frame-offset add and compare against the tag end.
// Reset is synchronous and clears the parse state to the start of a file.
// The input register keeps taking bytes while a summary waits, and stops only
// when the held byte cannot be parsed because the result register is full.
module id3v2_tag_frame_walker
   import id3fw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_end_of_stream,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_tag_found,
   output logic [7:0]         rsp_version_major,
   output logic [7:0]         rsp_version_revision,
   output logic [7:0]         rsp_header_flags,
   output logic [TOTAL_W-1:0] rsp_total_tag_size,
   output logic [COUNT_W-1:0] rsp_frame_count,
   output logic [PAD_W-1:0]   rsp_padding_size,
   output logic [1:0]         rsp_status
);

   req_type req_data;
   req_type item;
   logic    item_valid;
   logic    space;
   logic    fire;
   logic    emit;
   rsp_type result;
   rsp_type rsp_data;

   assign req_data.data_byte     = req_data_byte;
   assign req_data.end_of_stream = req_end_of_stream;
   // A byte that produces no summary never has to wait for the result register.
   assign fire = item_valid && (space || !emit);

   id3fw_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .take       (fire),
      .item_valid (item_valid),
      .item_data  (item)
   );

   id3fw_walker u_walker (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .emit   (emit),
      .result (result)
   );

   id3fw_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && emit),
      .load_data (result),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_tag_found        = rsp_data.tag_found;
   assign rsp_version_major    = rsp_data.version_major;
   assign rsp_version_revision = rsp_data.version_revision;
   assign rsp_header_flags     = rsp_data.header_flags;
   assign rsp_total_tag_size   = rsp_data.total_tag_size;
   assign rsp_frame_count      = rsp_data.frame_count;
   assign rsp_padding_size     = rsp_data.padding_size;
   assign rsp_status           = rsp_data.status;

endmodule
